// ----- rtl/id3fx_pkg.sv -----
package id3fx_pkg;

	// parser phases
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_ID,
		PH_SIZE,
		PH_FLAGS,
		PH_BODY
	} phase_t;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD     = 2'd0;
	localparam logic [1:0] KIND_END_MATCH   = 2'd1;
	localparam logic [1:0] KIND_END_NOMATCH = 2'd2;

	// first ID characters that select a frame class
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_A = 8'h41;

	// field positions
	localparam logic [3:0] HDR_SIZE_FIRST = 4'd6;
	localparam logic [3:0] HDR_LAST       = 4'd9;
	localparam logic [3:0] WORD_LAST      = 4'd3;
	localparam logic [3:0] FLAGS_LAST     = 4'd2;
	localparam logic [3:0] SHORT_RUN_MAX  = 4'd10;

	// register map
	localparam logic [2:0]  ADDR_WANTED_ID  = 3'd0;
	localparam logic [31:0] WANTED_ID_RESET = 32'h5449_5432;

	// result queue depth (power of two, at least 2)
	localparam int OUT_DEPTH = 4;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	// up to two results pushed per cycle
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

// ----- rtl/id3fx_cfg.sv -----
module id3fx_cfg
	import id3fx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [31:0] wanted_id
);

	logic [31:0] wanted_id_q;

	// register write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_id_q <= WANTED_ID_RESET;
		end else if (psel && penable && pwrite && (paddr == ADDR_WANTED_ID)) begin
			wanted_id_q <= pwdata;
		end
	end

	// read mux
	always_comb begin
		unique case (paddr)
			ADDR_WANTED_ID: prdata = wanted_id_q;
			default:        prdata = 32'd0;
		endcase
	end

	assign pready    = 1'b1;
	assign wanted_id = wanted_id_q;

endmodule

// ----- rtl/id3fx_parser.sv -----
module id3fx_parser
	import id3fx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        tag_start,
	input  logic [7:0]  data_byte,
	input  logic [31:0] wanted_id,
	input  logic        room,
	output push_t       push
);

	// input register
	logic       in_valid_s1;
	logic       tag_start_s1;
	logic [7:0] data_byte_s1;

	// parser state
	phase_t      phase_q,       phase_d;
	logic [3:0]  field_q,       field_d;
	logic [27:0] tag_size_q,    tag_size_d;
	logic [31:0] tag_count_q,   tag_count_d;
	logic [31:0] frame_id_q,    frame_id_d;
	logic [31:0] frame_size_q,  frame_size_d;
	logic [31:0] frame_count_q, frame_count_d;
	logic [3:0]  short_run_q,   short_run_d;
	logic        match_q,       match_d;

	logic        go;
	logic [31:0] tc_inc;
	logic [31:0] fc_inc;
	logic [27:0] ts_new;
	logic [31:0] fid_new;
	logic        emit;
	logic        tag_full;
	result_t     end_res;

	assign in_stall = in_valid_s1 && !room;
	assign go       = in_valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			tag_start_s1 <= tag_start;
			data_byte_s1 <= data_byte;
		end
	end

	// shared terms
	assign tc_inc   = (tag_count_q == 32'hFFFF_FFFF) ? tag_count_q : tag_count_q + 32'd1;
	assign fc_inc   = frame_count_q + 32'd1;
	assign tag_full = tc_inc >= {4'd0, tag_size_q};
	assign ts_new   = (field_q >= HDR_SIZE_FIRST) ?
	                  {tag_size_q[20:0], data_byte_s1[6:0]} : tag_size_q;
	assign fid_new  = (field_q == 4'd0) ? {24'd0, data_byte_s1} :
	                  {frame_id_q[23:0], data_byte_s1};
	assign end_res  = '{kind: (match_q ? KIND_END_MATCH : KIND_END_NOMATCH),
	                    out_byte: 8'd0, last: 1'b1};

	// per-byte state update and result generation
	always_comb begin
		phase_d       = phase_q;
		field_d       = field_q;
		tag_size_d    = tag_size_q;
		tag_count_d   = tag_count_q;
		frame_id_d    = frame_id_q;
		frame_size_d  = frame_size_q;
		frame_count_d = frame_count_q;
		short_run_d   = short_run_q;
		match_d       = match_q;
		emit          = 1'b0;
		push          = '0;
		if (go) begin
			if (tag_start_s1) begin
				phase_d     = PH_HEADER;
				field_d     = 4'd1;
				tag_size_d  = 28'd0;
				tag_count_d = 32'd0;
				match_d     = 1'b0;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						tag_size_d = ts_new;
						if (field_q >= HDR_LAST) begin
							tag_count_d = 32'd0;
							field_d     = 4'd0;
							if (ts_new == 28'd0) begin
								phase_d    = PH_IDLE;
								push.count = 2'd1;
								push.first = end_res;
							end else begin
								phase_d = PH_ID;
							end
						end else begin
							field_d = field_q + 4'd1;
						end
					end
					PH_ID: begin
						tag_count_d = tc_inc;
						if ((field_q == 4'd0) && (data_byte_s1 == 8'd0)) begin
							// padding ends the tag
							phase_d    = PH_IDLE;
							field_d    = 4'd0;
							push.count = 2'd1;
							push.first = end_res;
						end else begin
							frame_id_d = fid_new;
							if (field_q >= WORD_LAST) begin
								if (fid_new == wanted_id) begin
									match_d = 1'b1;
								end
								phase_d = PH_SIZE;
								field_d = 4'd0;
							end else begin
								field_d = field_q + 4'd1;
							end
						end
					end
					PH_SIZE: begin
						tag_count_d  = tc_inc;
						frame_size_d = (field_q == 4'd0) ? {24'd0, data_byte_s1} :
						               {frame_size_q[23:0], data_byte_s1};
						if (field_q >= WORD_LAST) begin
							phase_d = PH_FLAGS;
							field_d = 4'd0;
						end else begin
							field_d = field_q + 4'd1;
						end
					end
					PH_FLAGS: begin
						tag_count_d = tc_inc;
						if (field_q < FLAGS_LAST) begin
							field_d = field_q + 4'd1;
						end else begin
							// encoding byte is body byte one
							frame_count_d = 32'd1;
							short_run_d   = 4'd0;
							field_d       = 4'd0;
							phase_d       = PH_BODY;
							if (frame_size_q <= 32'd1) begin
								if (tag_full) begin
									phase_d    = PH_IDLE;
									push.count = 2'd1;
									push.first = end_res;
								end else begin
									phase_d = PH_ID;
								end
							end
						end
					end
					PH_BODY: begin
						tag_count_d   = tc_inc;
						frame_count_d = fc_inc;
						if (frame_id_q == wanted_id) begin
							if ((frame_id_q[31:24] == CH_T) || (frame_id_q[31:24] == CH_C)) begin
								emit = 1'b1;
							end else if ((frame_id_q[31:24] == CH_A) &&
							             (short_run_q < SHORT_RUN_MAX)) begin
								emit        = 1'b1;
								short_run_d = short_run_q + 4'd1;
							end
						end
						if (emit) begin
							push.count = 2'd1;
							push.first = '{kind: KIND_PAYLOAD, out_byte: data_byte_s1,
							               last: 1'b1};
						end
						if (fc_inc >= frame_size_q) begin
							field_d = 4'd0;
							if (tag_full) begin
								phase_d = PH_IDLE;
								if (emit) begin
									push.count      = 2'd2;
									push.first.last = 1'b0;
									push.second     = end_res;
								end else begin
									push.count = 2'd1;
									push.first = end_res;
								end
							end else begin
								phase_d = PH_ID;
							end
						end
					end
					default: begin
						// idle: stray bytes are dropped
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			field_q       <= 4'd0;
			tag_size_q    <= 28'd0;
			tag_count_q   <= 32'd0;
			frame_id_q    <= 32'd0;
			frame_size_q  <= 32'd0;
			frame_count_q <= 32'd0;
			short_run_q   <= 4'd0;
			match_q       <= 1'b0;
		end else begin
			phase_q       <= phase_d;
			field_q       <= field_d;
			tag_size_q    <= tag_size_d;
			tag_count_q   <= tag_count_d;
			frame_id_q    <= frame_id_d;
			frame_size_q  <= frame_size_d;
			frame_count_q <= frame_count_d;
			short_run_q   <= short_run_d;
			match_q       <= match_d;
		end
	end

	// two results come only from a body byte that closes the tag
	a_two_from_body: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (phase_q == PH_BODY) && (phase_d == PH_IDLE))
		else $error("two results outside a closing body byte");

	// nothing is pushed unless the queue had room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		!room |-> (push.count == 2'd0))
		else $error("push without queue room");

	// match flag is set only by a completed frame ID
	a_match_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(match_q) |-> ($past(phase_q) == PH_ID) && (phase_q == PH_SIZE))
		else $error("match flag set outside frame ID");

	// short-run count never passes its limit
	a_short_run: assert property (@(posedge clk) disable iff (!arst_n)
		short_run_q <= SHORT_RUN_MAX)
		else $error("short-run count overflow");

endmodule

// ----- rtl/id3fx_out_fifo.sv -----
module id3fx_out_fifo
	import id3fx_pkg::*;
#(
	parameter int DEPTH = OUT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	output logic       room,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	result_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            pop;

	// room for a two-result push
	assign room      = count_q <= CW'(DEPTH - 2);
	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;

	// entry storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + AW'(1)] <= push.second;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

	assign kind     = mem_q[rd_ptr_q].kind;
	assign out_byte = mem_q[rd_ptr_q].out_byte;
	assign last     = mem_q[rd_ptr_q].last;

	// fill count stays within the queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue overflow");

endmodule

// ----- rtl/id3v2_frame_select_extractor_unit.sv -----
// channel  | handshake            | payload
// ---------+----------------------+--------------------------
// input    | in_valid / in_stall  | tag_start, data_byte
// output   | out_valid / out_stall| kind, out_byte, last
// config   | APB psel/penable     | paddr, pwdata, prdata
//
// One byte per cycle is taken while the input does not stall; a byte passes
// through the input register and its results are queued before the output.
// A byte yields zero, one or two results; results go through a small queue,
// and the input stalls while the queue lacks room for two results.
// Reset clears the parser state and the queue; the frame ID register resets to "TIT2".
// An output stall backs up the queue and then the input register.
module id3v2_frame_select_extractor_unit
	import id3fx_pkg::*;
#(
	parameter int OUT_QUEUE_DEPTH = OUT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        tag_start,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] wanted_id;
	logic        room;
	push_t       push;

	id3fx_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.wanted_id (wanted_id)
	);

	id3fx_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.tag_start (tag_start),
		.data_byte (data_byte),
		.wanted_id (wanted_id),
		.room      (room),
		.push      (push)
	);

	id3fx_out_fifo #(
		.DEPTH (OUT_QUEUE_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
